/* rtl/core/playfair_pkg.sv */
// shared types, constants and helper functions of the playfair digraph cipher
`default_nettype none

package playfair_pkg;

   // request type codes
   localparam logic [1:0] REQ_KEY_LETTER = 2'd0;
   localparam logic [1:0] REQ_KEY_END    = 2'd1;
   localparam logic [1:0] REQ_PAIR       = 2'd2;

   // square geometry and letter constants
   localparam logic [4:0] CELLS       = 5'd25;
   localparam logic [4:0] LAST_LETTER = 5'd25;
   localparam logic [4:0] IDX_J       = 5'd9;
   localparam logic [2:0] LAST_COORD  = 3'd4;
   localparam logic [7:0] ASCII_UPPER_A = 8'd65;
   localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [7:0] ASCII_LOWER_A = 8'd97;
   localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
   localparam logic [6:0] OUT_BASE      = 7'd65;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_POS,
      ST_MAP,
      ST_EMIT
   } state_type;

   // case-folded letter: ok is low for non-letters and for J or j
   typedef struct packed {
      logic       ok;
      logic [4:0] idx;
   } letter_type;

   // command to the shared placement unit
   typedef struct packed {
      logic       place;
      logic       clear;
      logic [4:0] idx;
   } place_cmd_type;

   // a two-address read of one of the square stores
   typedef struct packed {
      logic       en;
      logic [4:0] addr_a;
      logic [4:0] addr_b;
   } read_cmd_type;

   function automatic letter_type fold_letter(input logic [7:0] code);
      letter_type res;
      logic [7:0] diff;
      res  = '0;
      diff = '0;
      if (code >= ASCII_UPPER_A && code <= ASCII_UPPER_Z) begin
         diff    = code - ASCII_UPPER_A;
         res.ok  = 1'b1;
         res.idx = diff[4:0];
      end else if (code >= ASCII_LOWER_A && code <= ASCII_LOWER_Z) begin
         diff    = code - ASCII_LOWER_A;
         res.ok  = 1'b1;
         res.idx = diff[4:0];
      end
      if (res.idx == IDX_J) begin
         res.ok = 1'b0;
      end
      return res;
   endfunction

   // row of a cell number 0..24
   function automatic logic [2:0] pos_row(input logic [4:0] pos);
      logic [2:0] row;
      if (pos >= 5'd20) begin
         row = 3'd4;
      end else if (pos >= 5'd15) begin
         row = 3'd3;
      end else if (pos >= 5'd10) begin
         row = 3'd2;
      end else if (pos >= 5'd5) begin
         row = 3'd1;
      end else begin
         row = 3'd0;
      end
      return row;
   endfunction

   // row times five, as a cell number
   function automatic logic [4:0] row_base(input logic [2:0] row);
      return {row, 2'b00} + {2'b00, row};
   endfunction

   // one step around the square, forward or back
   function automatic logic [2:0] step_coord(input logic [2:0] v, input logic back);
      logic [2:0] res;
      if (back) begin
         res = (v == 3'd0) ? LAST_COORD : v - 3'd1;
      end else begin
         res = (v == LAST_COORD) ? 3'd0 : v + 3'd1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/playfair_if.sv */
// request, response and register-write channel interfaces
`default_nettype none

interface playfair_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] letter_a;
   logic [7:0] letter_b;

   modport source (output valid, req_type, letter_a, letter_b, input ready);
   modport sink   (input valid, req_type, letter_a, letter_b, output ready);
endinterface

interface playfair_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_a;
   logic [6:0] out_b;
   logic       error_flag;

   modport source (output valid, out_a, out_b, error_flag, input ready);
   modport sink   (input valid, out_a, out_b, error_flag, output ready);
endinterface

interface playfair_csr_if;
   logic valid;
   logic ready;
   logic decrypt_mode;

   modport source (output valid, decrypt_mode, input ready);
   modport sink   (input valid, decrypt_mode, output ready);
endinterface

`default_nettype wire

/* rtl/core/playfair_digraph_cipher.sv */
// playfair digraph cipher: key square builder and pair enciphering sequencer
//
// req_ch carries requests: a key letter, a key end, or a letter pair.
// Key letters are folded to upper case; non-letters and J are dropped.
// A key end on a square not yet ready has one placement unit sweep the
// alphabet into the free cells, one letter a cycle. A pair passes a
// position read, a cell read through the pair rules, then the write of
// the result into the rsp_ch register, which waits until that register
// is free. A pair that fails (square not ready, or a letter not in the
// square) skips both reads and returns zeros with error_flag set.
// Key requests give no result. req_ch.ready is high only between requests.
// csr_ch writes decrypt_mode at any time it is valid; write it only when
// the block is idle. Reset clears the square, the mode and any result.
// When the receiver stalls, the result is held in its register and the
// block still takes key requests; a further pair is taken but holds in its
// last step until the result register is free.
`default_nettype none

module playfair_digraph_cipher
   import playfair_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   playfair_req_if.sink   req_ch,
   playfair_rsp_if.source rsp_ch,
   playfair_csr_if.sink   csr_ch
);

   state_type     state_ff;
   state_type     state_in;
   logic [4:0]    a_idx_ff;
   logic [4:0]    b_idx_ff;
   logic          err_ff;
   logic [4:0]    sweep_ff;
   logic          square_ready_ff;
   logic          decrypt_mode_ff;
   logic          rsp_valid_ff;
   logic [6:0]    out_a_ff;
   logic [6:0]    out_b_ff;
   logic          error_flag_ff;
   logic          req_ready;
   logic          req_fire;
   logic          slot_free;
   logic          pair_bad;
   letter_type    fold_a;
   letter_type    fold_b;
   place_cmd_type place_cmd;
   read_cmd_type  pos_rd;
   read_cmd_type  cell_rd;
   logic [4:0]    pos_a;
   logic [4:0]    pos_b;
   logic [4:0]    cell_a;
   logic [4:0]    cell_b;
   logic [4:0]    map_a;
   logic [4:0]    map_b;

   playfair_square u_square (
      .clock     (clock),
      .reset     (reset),
      .place_cmd (place_cmd),
      .pos_rd    (pos_rd),
      .cell_rd   (cell_rd),
      .pos_a_ff  (pos_a),
      .pos_b_ff  (pos_b),
      .cell_a_ff (cell_a),
      .cell_b_ff (cell_b)
   );

   playfair_coord u_coord (
      .back   (decrypt_mode_ff),
      .pos_a  (pos_a),
      .pos_b  (pos_b),
      .cell_a (map_a),
      .cell_b (map_b)
   );

   // channel decode
   assign fold_a    = fold_letter(req_ch.letter_a);
   assign fold_b    = fold_letter(req_ch.letter_b);
   assign req_fire  = req_ch.valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign pair_bad  = !square_ready_ff || !fold_a.ok || !fold_b.ok;

   assign req_ch.ready      = req_ready;
   assign csr_ch.ready      = 1'b1;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_a      = out_a_ff;
   assign rsp_ch.out_b      = out_b_ff;
   assign rsp_ch.error_flag = error_flag_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.req_type == REQ_KEY_END && !square_ready_ff) begin
                  state_in = ST_SWEEP;
               end else if (req_ch.req_type == REQ_PAIR) begin
                  state_in = pair_bad ? ST_EMIT : ST_POS;
               end
            end
         end
         ST_SWEEP: begin
            if (sweep_ff == LAST_LETTER) begin
               state_in = ST_IDLE;
            end
         end
         ST_POS: begin
            state_in = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      place_cmd = '0;
      pos_rd    = '0;
      cell_rd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire && req_ch.req_type == REQ_KEY_LETTER && fold_a.ok) begin
               place_cmd.place = 1'b1;
               place_cmd.clear = square_ready_ff;
               place_cmd.idx   = fold_a.idx;
            end
         end
         ST_SWEEP: begin
            place_cmd.place = (sweep_ff != IDX_J);
            place_cmd.idx   = sweep_ff;
         end
         ST_POS: begin
            pos_rd.en     = 1'b1;
            pos_rd.addr_a = a_idx_ff;
            pos_rd.addr_b = b_idx_ff;
         end
         ST_MAP: begin
            cell_rd.en     = 1'b1;
            cell_rd.addr_a = map_a;
            cell_rd.addr_b = map_b;
         end
         ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         sweep_ff        <= '0;
         square_ready_ff <= 1'b0;
         decrypt_mode_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_ch.valid) begin
            decrypt_mode_ff <= csr_ch.decrypt_mode;
         end

         // alphabet sweep counter and square ready flag
         if (state_ff == ST_SWEEP) begin
            sweep_ff <= sweep_ff + 5'd1;
            if (sweep_ff == LAST_LETTER) begin
               square_ready_ff <= 1'b1;
            end
         end else begin
            sweep_ff <= '0;
         end
         if (req_fire && req_ch.req_type == REQ_KEY_LETTER && fold_a.ok) begin
            square_ready_ff <= 1'b0;
         end

         // response valid
         if (state_ff == ST_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // pair payload registers
   always_ff @(posedge clock) begin
      if (req_fire && req_ch.req_type == REQ_PAIR) begin
         a_idx_ff <= fold_a.idx;
         b_idx_ff <= fold_b.idx;
         err_ff   <= pair_bad;
      end
      if (state_ff == ST_EMIT && slot_free) begin
         out_a_ff      <= err_ff ? 7'd0 : OUT_BASE + {2'b00, cell_a};
         out_b_ff      <= err_ff ? 7'd0 : OUT_BASE + {2'b00, cell_b};
         error_flag_ff <= err_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/playfair_coord.sv */
// playfair pair rules: maps two square positions to the two output cells
`default_nettype none

module playfair_coord
   import playfair_pkg::*;
(
   input  wire logic       back,
   input  wire logic [4:0] pos_a,
   input  wire logic [4:0] pos_b,
   output logic      [4:0] cell_a,
   output logic      [4:0] cell_b
);

   logic [2:0] row_a;
   logic [2:0] row_b;
   logic [2:0] col_a;
   logic [2:0] col_b;
   logic [4:0] col_a_full;
   logic [4:0] col_b_full;
   logic [2:0] new_row_a;
   logic [2:0] new_row_b;
   logic [2:0] new_col_a;
   logic [2:0] new_col_b;

   // split cell numbers into row and column
   always_comb begin
      row_a      = pos_row(pos_a);
      row_b      = pos_row(pos_b);
      col_a_full = pos_a - row_base(row_a);
      col_b_full = pos_b - row_base(row_b);
      col_a      = col_a_full[2:0];
      col_b      = col_b_full[2:0];
   end

   // same row, same column, or rectangle
   always_comb begin
      new_row_a = row_a;
      new_row_b = row_b;
      new_col_a = col_a;
      new_col_b = col_b;
      priority if (row_a == row_b) begin
         new_col_a = step_coord(col_a, back);
         new_col_b = step_coord(col_b, back);
      end else if (col_a == col_b) begin
         new_row_a = step_coord(row_a, back);
         new_row_b = step_coord(row_b, back);
      end else begin
         new_col_a = col_b;
         new_col_b = col_a;
      end
   end

   assign cell_a = row_base(new_row_a) + {2'b00, new_col_a};
   assign cell_b = row_base(new_row_b) + {2'b00, new_col_b};

endmodule

`default_nettype wire

/* rtl/core/playfair_square.sv */
// key square stores and the shared letter placement unit
`default_nettype none

module playfair_square
   import playfair_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire place_cmd_type place_cmd,
   input  wire read_cmd_type  pos_rd,
   input  wire read_cmd_type  cell_rd,
   output logic         [4:0] pos_a_ff,
   output logic         [4:0] pos_b_ff,
   output logic         [4:0] cell_a_ff,
   output logic         [4:0] cell_b_ff
);

   logic [4:0]  cells_mem [0:24];
   logic [4:0]  pos_mem   [0:25];
   logic [25:0] used_ff;
   logic [25:0] used_in;
   logic [4:0]  fill_ff;
   logic [4:0]  fill_in;
   logic        used_now;
   logic [4:0]  fill_now;
   logic        do_place;

   // placement decision, seen against a cleared square when starting afresh
   always_comb begin
      used_now = place_cmd.clear ? 1'b0 : used_ff[place_cmd.idx];
      fill_now = place_cmd.clear ? 5'd0 : fill_ff;
      do_place = place_cmd.place && !used_now && (fill_now < CELLS);
   end

   always_comb begin
      used_in = place_cmd.clear ? '0 : used_ff;
      fill_in = fill_now;
      if (do_place) begin
         used_in[place_cmd.idx] = 1'b1;
         fill_in                = fill_now + 5'd1;
      end
   end

   // used flags and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         fill_ff <= '0;
      end else begin
         used_ff <= used_in;
         fill_ff <= fill_in;
      end
   end

   // cell and position stores
   always_ff @(posedge clock) begin
      if (do_place) begin
         cells_mem[fill_now]     <= place_cmd.idx;
         pos_mem[place_cmd.idx]  <= fill_now;
      end
   end

   // registered position reads
   always_ff @(posedge clock) begin
      if (pos_rd.en) begin
         pos_a_ff <= pos_mem[pos_rd.addr_a];
         pos_b_ff <= pos_mem[pos_rd.addr_b];
      end
   end

   // registered cell reads
   always_ff @(posedge clock) begin
      if (cell_rd.en) begin
         cell_a_ff <= cells_mem[cell_rd.addr_a];
         cell_b_ff <= cells_mem[cell_rd.addr_b];
      end
   end

endmodule

`default_nettype wire

/* bench/playfair_digraph_cipher_test.sv */
// self-checking bench for the playfair digraph cipher: key squares, pairs and mode
`timescale 1ns / 100ps

module playfair_digraph_cipher_test;
   import playfair_pkg::*;

   // request type that the block ignores
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SIDE = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 250;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] letter_a;
      logic [7:0] letter_b;
   } cipher_request_type;

   typedef struct packed {
      logic [6:0] out_a;
      logic [6:0] out_b;
      logic       error_flag;
   } digraph_result_type;

   logic clock = 1'b0;
   logic reset;

   playfair_req_if req_ch ();
   playfair_rsp_if rsp_ch ();
   playfair_csr_if csr_ch ();

   playfair_digraph_cipher DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // pending requests, expected digraphs and counters
   cipher_request_type pending_requests[$];
   digraph_result_type expected_digraphs[$];
   digraph_result_type want_rsp;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              phase_items = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   logic            req_hs = 1'b0;

   // own copy of the key square and the mode
   logic [4:0] sq_cells [25];
   logic [4:0] sq_pos [26];
   logic       sq_used [26];
   int         sq_fill;
   logic       sq_ready;
   logic       cipher_decrypt;

   always #4 clock = ~clock;

   // case folding: ok is low for non-letters, J and j
   function automatic void fold_code(input logic [7:0] code, output logic ok,
                                     output logic [4:0] idx);
      logic [7:0] diff;
      ok   = 1'b0;
      idx  = '0;
      diff = '0;
      if (code >= ASCII_UPPER_A && code <= ASCII_UPPER_Z) begin
         diff = code - ASCII_UPPER_A;
         ok   = 1'b1;
      end else if (code >= ASCII_LOWER_A && code <= ASCII_LOWER_Z) begin
         diff = code - ASCII_LOWER_A;
         ok   = 1'b1;
      end
      idx = diff[4:0];
      if (ok && idx == IDX_J) begin
         ok = 1'b0;
      end
   endfunction

   function automatic int step_wrap(input int v, input logic back);
      return back ? (v + SIDE - 1) % SIDE : (v + 1) % SIDE;
   endfunction

   task automatic place_in_square(input logic [4:0] idx);
      if (!sq_used[idx] && sq_fill < int'(CELLS)) begin
         sq_used[idx]     = 1'b1;
         sq_cells[sq_fill] = idx;
         sq_pos[idx]      = sq_fill[4:0];
         sq_fill++;
      end
   endtask

   // advance the square for one accepted request, queue any digraph it gives
   task automatic apply_request(input cipher_request_type rq);
      logic            ok_a, ok_b;
      logic [4:0]      ia, ib;
      int              ra, ca, rb, cb, t;
      digraph_result_type res;
      fold_code(rq.letter_a, ok_a, ia);
      fold_code(rq.letter_b, ok_b, ib);
      case (rq.kind)
         REQ_KEY_LETTER: begin
            if (ok_a) begin
               // a key letter on a finished square starts a fresh one
               if (sq_ready) begin
                  foreach (sq_used[i]) sq_used[i] = 1'b0;
                  sq_fill  = 0;
                  sq_ready = 1'b0;
               end
               place_in_square(ia);
            end
         end
         REQ_KEY_END: begin
            if (!sq_ready) begin
               for (int i = 0; i <= int'(LAST_LETTER); i++) begin
                  if (i != int'(IDX_J)) place_in_square(i[4:0]);
               end
               sq_ready = 1'b1;
            end
         end
         REQ_PAIR: begin
            if (!sq_ready || !ok_a || !ok_b) begin
               res = '{out_a: '0, out_b: '0, error_flag: 1'b1};
            end else begin
               ra = int'(sq_pos[ia]) / SIDE;
               ca = int'(sq_pos[ia]) % SIDE;
               rb = int'(sq_pos[ib]) / SIDE;
               cb = int'(sq_pos[ib]) % SIDE;
               if (ra == rb) begin
                  ca = step_wrap(ca, cipher_decrypt);
                  cb = step_wrap(cb, cipher_decrypt);
               end else if (ca == cb) begin
                  ra = step_wrap(ra, cipher_decrypt);
                  rb = step_wrap(rb, cipher_decrypt);
               end else begin
                  t  = ca;
                  ca = cb;
                  cb = t;
               end
               res.out_a      = OUT_BASE + {2'b00, sq_cells[ra * SIDE + ca]};
               res.out_b      = OUT_BASE + {2'b00, sq_cells[rb * SIDE + cb]};
               res.error_flag = 1'b0;
            end
            expected_digraphs.push_back(res);
         end
         default: ;
      endcase
   endtask

   // request driver, fed from the pending queue
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_hs) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            cipher_request_type rq;
            rq = pending_requests.pop_front();
            req_ch.req_type <= rq.kind;
            req_ch.letter_a <= rq.letter_a;
            req_ch.letter_b <= rq.letter_b;
            req_ch.valid    <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // monitor: check responses, track mode writes, predict accepted requests
   always @(posedge clock) begin
      req_hs <= req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_digraphs.size() == 0) begin
               $error("unexpected response: out_a %0d out_b %0d error_flag %0d",
                      rsp_ch.out_a, rsp_ch.out_b, rsp_ch.error_flag);
               mismatch_count++;
            end else begin
               want_rsp = expected_digraphs.pop_front();
               if (rsp_ch.out_a !== want_rsp.out_a) begin
                  $error("out_a: expected %0d, actual %0d", want_rsp.out_a, rsp_ch.out_a);
                  mismatch_count++;
               end
               if (rsp_ch.out_b !== want_rsp.out_b) begin
                  $error("out_b: expected %0d, actual %0d", want_rsp.out_b, rsp_ch.out_b);
                  mismatch_count++;
               end
               if (rsp_ch.error_flag !== want_rsp.error_flag) begin
                  $error("error_flag: expected %0d, actual %0d",
                         want_rsp.error_flag, rsp_ch.error_flag);
                  mismatch_count++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            cipher_decrypt = csr_ch.decrypt_mode;
         end
         if (req_ch.valid && req_ch.ready) begin
            apply_request('{kind: req_ch.req_type, letter_a: req_ch.letter_a,
                            letter_b: req_ch.letter_b});
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic push_request(input logic [1:0] kind, input logic [7:0] a,
                               input logic [7:0] b);
      pending_requests.push_back('{kind: kind, letter_a: a, letter_b: b});
      phase_items++;
   endtask

   // a random letter other than J, in either case
   function automatic logic [7:0] pick_letter();
      int unsigned idx;
      idx = $urandom_range(0, 24);
      if (idx >= IDX_J) idx++;
      return ($urandom_range(0, 1) ? ASCII_LOWER_A : ASCII_UPPER_A) + idx[7:0];
   endfunction

   // a random byte
   function automatic logic [7:0] pick_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // a byte that is mostly not a usable letter
   function automatic logic [7:0] pick_odd_byte();
      case ($urandom_range(0, 2))
         0:       return ASCII_UPPER_A + IDX_J;
         1:       return ASCII_LOWER_A + IDX_J;
         default: return pick_byte();
      endcase
   endfunction

   task automatic write_mode(input logic mode);
      @(negedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.decrypt_mode <= mode;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // wait until all requests are taken and answered, then let a key end finish
   task automatic settle_block();
      while (pending_requests.size() != 0 || req_ch.valid || expected_digraphs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random stimulus: mostly whole key phrases followed by pairs, some noise
   task automatic queue_random(input int target);
      int unsigned klen, npairs;
      logic [7:0]  a;
      phase_items = 0;
      while (phase_items < target) begin
         if ($urandom_range(0, 99) < 80) begin
            klen = $urandom_range(0, 10);
            for (int i = 0; i < int'(klen); i++) begin
               if ($urandom_range(0, 9) == 0)
                  push_request(REQ_KEY_LETTER, pick_odd_byte(), pick_byte());
               else
                  push_request(REQ_KEY_LETTER, pick_letter(), pick_byte());
            end
            if ($urandom_range(0, 9) == 0)
               push_request(REQ_PAIR, pick_letter(), pick_letter());
            push_request(REQ_KEY_END, pick_byte(), pick_byte());
            npairs = $urandom_range(4, 20);
            for (int i = 0; i < int'(npairs); i++) begin
               a = pick_letter();
               case ($urandom_range(0, 19))
                  0:       push_request(REQ_PAIR, pick_odd_byte(), pick_letter());
                  1:       push_request(REQ_PAIR, pick_letter(), pick_odd_byte());
                  2:       push_request(REQ_PAIR, a, a);
                  3:       push_request(REQ_KEY_END, a, pick_letter());
                  default: push_request(REQ_PAIR, a, pick_letter());
               endcase
            end
         end else begin
            npairs = $urandom_range(1, 4);
            for (int i = 0; i < int'(npairs); i++)
               push_request(2'($urandom_range(0, 3)), pick_byte(), pick_byte());
         end
      end
   endtask

   initial begin
      // known inputs and reset state of the predictor
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_KEY_LETTER;
      req_ch.letter_a     = '0;
      req_ch.letter_b     = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.decrypt_mode = 1'b0;
      foreach (sq_cells[i]) sq_cells[i] = '0;
      foreach (sq_pos[i]) sq_pos[i] = '0;
      foreach (sq_used[i]) sq_used[i] = 1'b0;
      sq_fill        = 0;
      sq_ready       = 1'b0;
      cipher_decrypt = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty key, a keyed square, the pair rules and error cases
      write_mode(1'b0);
      push_request(REQ_PAIR, "A", "B");
      push_request(REQ_KEY_END, 8'h00, 8'h00);
      push_request(REQ_PAIR, "A", "B");
      push_request(REQ_KEY_LETTER, "P", 8'hFF);
      push_request(REQ_PAIR, "A", "B");
      push_request(REQ_KEY_LETTER, "l", 8'h00);
      push_request(REQ_KEY_LETTER, "a", 8'h00);
      push_request(REQ_KEY_LETTER, "1", 8'h00);
      push_request(REQ_KEY_LETTER, "j", 8'h00);
      push_request(REQ_KEY_LETTER, "J", 8'h00);
      push_request(REQ_KEY_LETTER, "Y", 8'h00);
      push_request(REQ_KEY_LETTER, "F", 8'h00);
      push_request(REQ_KEY_LETTER, "A", 8'h00);
      push_request(REQ_KEY_LETTER, 8'hFF, 8'h00);
      push_request(REQ_KEY_END, 8'hFF, 8'hFF);
      push_request(REQ_KEY_END, 8'h00, 8'h00);
      push_request(REQ_PAIR, "H", "I");
      push_request(REQ_PAIR, "d", "e");
      push_request(REQ_PAIR, "P", "B");
      push_request(REQ_PAIR, "Z", "F");
      push_request(REQ_PAIR, "F", "P");
      push_request(REQ_PAIR, "E", "E");
      push_request(REQ_PAIR, "J", "A");
      push_request(REQ_PAIR, "A", 8'h00);
      push_request(REQ_PAIR, 8'hFF, "z");
      push_request(REQ_UNUSED, 8'hFF, 8'hFF);
      settle_block();

      // random phases: both modes under each idling pattern
      for (int p = 0; p < 8; p++) begin
         write_mode(~p[0]);
         case (p / 2)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 51; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 51; end
            default: begin send_idle_pct = 9;  rsp_stall_pct = 9;  end
         endcase
         queue_random(PHASE_ITEMS);
         settle_block();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/playfair_pkg.sv
rtl/core/playfair_if.sv
rtl/core/playfair_coord.sv
rtl/core/playfair_square.sv
rtl/core/playfair_digraph_cipher.sv
bench/playfair_digraph_cipher_test.sv
